// ----- hw/rtl/fir_filter_clipped_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the FIR core checker
// Clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_CLIPPED_CORE_MACROS_SVH
`define FIR_FILTER_CLIPPED_CORE_MACROS_SVH

// same-cycle implication
`define FCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fcc_pkg.sv -----
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants of the clipped FIR filter core.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TAPCNT_W   = 7;
    localparam int CLIP_W     = 15;
    localparam int COEF_W     = 32;
    localparam int COEF_IDX_W = 6;
    localparam int ACC_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MAX  = 2'd1;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd32767;

    // partial sums saturate at +/- 2^62
    localparam logic signed [ACC_W-1:0] ACC_LIMIT = 64'sh4000_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic shift;   // take the neighbour's sample: new item enters history
        logic rotate;  // whole ring moves one place towards cell 0
    } t_cell_ctl;

    typedef struct packed {
        logic clear;   // zero the accumulator
        logic tap_en;  // product of this cycle belongs to an active tap
    } t_mac_ctl;

endpackage

// ----- hw/rtl/fcc_cell.sv -----
// ----------------------------------------------------------------------------
// fcc_cell
// One tap of the ring: a history sample and its coefficient.
// ----------------------------------------------------------------------------
module fcc_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fcc_pkg::t_cell_ctl                   i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]        i_hist_prev,
    input  logic signed [SAMPLE_BITS-1:0]        i_hist_next,
    input  logic signed [fcc_pkg::COEF_W-1:0]    i_coef_next,
    input  logic signed [fcc_pkg::COEF_W-1:0]    i_coef_data,
    input  logic                                 i_coef_we,
    output logic signed [SAMPLE_BITS-1:0]        o_hist,
    output logic signed [fcc_pkg::COEF_W-1:0]    o_coef
);

    logic signed [SAMPLE_BITS-1:0]     r_hist;
    logic signed [fcc_pkg::COEF_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_coef <= '0;
        end else begin
            if (i_ctl.shift) begin
                r_hist <= i_hist_prev;
            end else if (i_ctl.rotate) begin
                r_hist <= i_hist_next;
            end
            if (i_ctl.rotate) begin
                r_coef <= i_coef_next;
            end else if (i_coef_we) begin
                r_coef <= i_coef_data;
            end
        end
    end

    assign o_hist = r_hist;
    assign o_coef = r_coef;

endmodule

// ----- hw/rtl/fcc_mac.sv -----
// ----------------------------------------------------------------------------
// fcc_mac
// Multiply-accumulate at the head of the ring, with clamp and scaling.
// ----------------------------------------------------------------------------
module fcc_mac #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fcc_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]        i_hist,
    input  logic signed [fcc_pkg::COEF_W-1:0]    i_coef,
    input  logic [fcc_pkg::CLIP_W-1:0]           i_clip_max,
    output logic signed [SAMPLE_BITS-1:0]        o_result
);

    localparam int PROD_W = fcc_pkg::COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = fcc_pkg::ACC_W;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [ACC_W-1:0]  w_sum_sat;
    logic signed [ACC_W-1:0]  w_lim;
    logic signed [ACC_W-1:0]  w_clamped;
    logic signed [ACC_W-1:0]  w_scaled;

    assign w_prod = i_hist * i_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.tap_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    always_comb begin
        w_sum = r_acc + ACC_W'(r_prod);
        if (w_sum > fcc_pkg::ACC_LIMIT) begin
            w_sum_sat = fcc_pkg::ACC_LIMIT;
        end else if (w_sum < -fcc_pkg::ACC_LIMIT) begin
            w_sum_sat = -fcc_pkg::ACC_LIMIT;
        end else begin
            w_sum_sat = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= w_sum_sat;
        end
    end

    // symmetric clamp to clip_max in Q(FRAC_BITS), then floor shift
    always_comb begin
        w_lim = $signed(ACC_W'(i_clip_max) << FRAC_BITS);
        if (r_acc > w_lim) begin
            w_clamped = w_lim;
        end else if (r_acc < -w_lim) begin
            w_clamped = -w_lim;
        end else begin
            w_clamped = r_acc;
        end
        w_scaled = w_clamped >>> FRAC_BITS;
    end

    assign o_result = w_scaled[SAMPLE_BITS-1:0];

endmodule

// ----- hw/rtl/fir_filter_clipped_core.sv -----
// ----------------------------------------------------------------------------
// fir_filter_clipped_core
// Direct-form FIR filter with symmetric output saturation. Taps live in a
// ring of cells that rotates past one shared multiply-accumulate unit.
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_ready   cmd, sample_in, coef_index,
//                                                 coef_value, last_in
//  out       source     o_out_valid / i_out_ready sample_out, last_out
//  cfg       sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
//  A sample item holds the core for the shift into history, TAPS rotations
//  past the multiplier, a product drain and the clamp into the output
//  register. A coefficient load is taken while idle and leaves the core idle.
//  Reset clears history and coefficients in the cells at once; no sweep.
//  While the output register still holds an unread item the core waits in the
//  clamp step and takes no item.
// ----------------------------------------------------------------------------
module fir_filter_clipped_core #(
    parameter int TAPS        = 64,
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    input  logic [fcc_pkg::COEF_IDX_W-1:0]        i_coef_index,
    input  logic signed [fcc_pkg::COEF_W-1:0]     i_coef_value,
    input  logic                                  i_last_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out,
    output logic                                  o_last_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int IW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CMPW = (IW > fcc_pkg::TAPCNT_W) ? IW : fcc_pkg::TAPCNT_W;

    fcc_pkg::t_state   r_state, n_state;
    fcc_pkg::t_cell_ctl w_cell_ctl;
    fcc_pkg::t_mac_ctl  w_mac_ctl;

    logic [fcc_pkg::TAPCNT_W-1:0] r_tap_count;
    logic [fcc_pkg::CLIP_W-1:0]   r_clip_max;
    logic [IW-1:0]                r_tap_idx;
    logic                         w_last_tap;
    logic                         w_in_ready;
    logic                         w_coef_load;
    logic                         w_out_load;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                         r_last;
    logic                         r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic                         r_last_out;
    logic signed [SAMPLE_BITS-1:0] w_mac_result;

    logic signed [SAMPLE_BITS-1:0]     w_hist [TAPS];
    logic signed [fcc_pkg::COEF_W-1:0] w_coef [TAPS];
    logic [TAPS-1:0]                   w_coef_we;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= '0;
            r_clip_max  <= fcc_pkg::CLIP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fcc_pkg::CFG_TAP_COUNT: r_tap_count <= i_cfg_data[fcc_pkg::TAPCNT_W-1:0];
                fcc_pkg::CFG_CLIP_MAX:  r_clip_max  <= i_cfg_data[fcc_pkg::CLIP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    assign w_last_tap = (r_tap_idx == IW'(TAPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_cell_ctl = '0;
        w_mac_ctl  = '0;
        w_out_load = 1'b0;
        unique case (r_state)
            fcc_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid && i_cmd == fcc_pkg::CMD_FILTER) begin
                    w_cell_ctl.shift = 1'b1;
                    w_mac_ctl.clear  = 1'b1;
                    n_state          = fcc_pkg::ST_RUN;
                end
            end
            fcc_pkg::ST_RUN: begin
                w_cell_ctl.rotate = 1'b1;
                w_mac_ctl.tap_en  = (CMPW'(r_tap_idx) < CMPW'(r_tap_count));
                if (w_last_tap) begin
                    n_state = fcc_pkg::ST_FLUSH;
                end
            end
            fcc_pkg::ST_FLUSH: begin
                n_state = fcc_pkg::ST_DONE;
            end
            fcc_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = fcc_pkg::ST_IDLE;
                end
            end
            default: n_state = fcc_pkg::ST_IDLE;
        endcase
    end

    assign o_in_ready  = w_in_ready;
    assign w_coef_load = w_in_ready && i_in_valid && (i_cmd == fcc_pkg::CMD_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_idx <= '0;
        end else if (r_state == fcc_pkg::ST_RUN) begin
            r_tap_idx <= w_last_tap ? '0 : r_tap_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cell_ctl.shift) begin
            r_sample <= i_sample_in;
            r_last   <= i_last_in;
        end
    end

    // ring of tap cells; cell 0 faces the multiplier
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        localparam int NXT = (g + 1) % TAPS;

        assign w_coef_we[g] = w_coef_load && (32'(i_coef_index) == 32'(g));

        fcc_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_cell_ctl),
            .i_hist_prev ((g == 0) ? i_sample_in : w_hist[(g == 0) ? 0 : g - 1]),
            .i_hist_next (w_hist[NXT]),
            .i_coef_next (w_coef[NXT]),
            .i_coef_data (i_coef_value),
            .i_coef_we   (w_coef_we[g]),
            .o_hist      (w_hist[g]),
            .o_coef      (w_coef[g])
        );
    end

    fcc_mac #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mac_ctl),
        .i_hist     (w_hist[0]),
        .i_coef     (w_coef[0]),
        .i_clip_max (r_clip_max),
        .o_result   (w_mac_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            // zero taps: bypass the sample
            r_sample_out <= (r_tap_count == '0) ? r_sample : w_mac_result;
            r_last_out   <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_last_out   = r_last_out;

endmodule

// ----- hw/rtl/fcc_checker.sv -----
// ----------------------------------------------------------------------------
// fcc_checker
// Port-level checks on the FIR core, bound to the top level.
// ----------------------------------------------------------------------------
`include "fir_filter_clipped_core_macros.svh"

module fcc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic i_cmd,
    input logic o_out_valid,
    input logic i_out_ready
);

    logic w_take_sample;
    logic w_take_load;

    assign w_take_sample = i_in_valid && o_in_ready && (i_cmd == fcc_pkg::CMD_FILTER);
    assign w_take_load   = i_in_valid && o_in_ready && (i_cmd == fcc_pkg::CMD_LOAD);

    `FCC_ASSERT_NEXT(a_out_holds, o_out_valid && !i_out_ready, o_out_valid, "out item dropped while stalled")
    `FCC_ASSERT_NEXT(a_busy_after_sample, w_take_sample, !o_in_ready, "in ready while a sample is in work")
    `FCC_ASSERT_NEXT(a_no_early_result, w_take_sample && !o_out_valid, !o_out_valid, "result one cycle after sample item")
    `FCC_ASSERT_NEXT(a_load_silent, w_take_load && !o_out_valid, !o_out_valid, "coefficient load gave an out item")

endmodule

bind fir_filter_clipped_core fcc_checker u_fcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

// ----- tb/sv/fir_filter_clipped_core_tb.sv -----
// ----------------------------------------------------------------------------
// fir_filter_clipped_core_tb
// Self-checking bench for the clipped FIR core. A short stimulus table covers
// bypass, extreme samples and coefficients, saturation and the limit
// registers. Random segments follow, each under a fresh tap count and limit.
// A bit-true filter model held here predicts each sample unless a row types it in.
// ----------------------------------------------------------------------------
module fir_filter_clipped_core_tb;

    import fcc_pkg::*;

    localparam int TAPS  = 64;
    localparam int FRAC  = 16;
    localparam int SW    = 16;
    localparam int DRAIN = 70;    // room for a sample to pass through the core
    localparam int N_DIR = 31;
    localparam int N_SEG = 11;
    localparam int SEG_ITEMS = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam longint SUM_BOUND = 64'sd1 <<< 62;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic                       cmd;
        logic signed [SW-1:0]       smp;
        logic [COEF_IDX_W-1:0]      idx;
        logic signed [COEF_W-1:0]   coef;
        logic                       lst;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [CFG_DATA_W-1:0]      reg_data;
        logic                       known;   // want holds the typed-in answer
        logic signed [SW-1:0]       want;
    } t_row;

    typedef struct packed {
        logic signed [SW-1:0] smp;
        logic                 lst;
    } t_out_sample;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          in_cmd = CMD_FILTER;
    logic signed [SW-1:0]          in_sample = '0;
    logic [COEF_IDX_W-1:0]         in_coef_idx = '0;
    logic signed [COEF_W-1:0]      in_coef = '0;
    logic                          in_last = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SW-1:0]          out_sample;
    logic                          out_last;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_idx = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    // filter state as the core should hold it
    logic signed [SW-1:0]          hist [TAPS] = '{default: '0};
    logic signed [COEF_W-1:0]      coef_tab [TAPS] = '{default: '0};
    logic [TAPCNT_W-1:0]           taps_r = '0;
    logic [CLIP_W-1:0]             clip_r = CLIP_RESET;

    t_out_sample expected_samples [$];

    int send_idle = 25;
    int recv_idle = 86;
    int n_bad = 0;
    int n_samples = 0;
    int n_loads = 0;
    int n_regs = 0;
    int n_clipped = 0;

    t_row dir_tab [N_DIR] = '{
        // bypass after reset: samples come straight out
        '{ROW_ITEM, CMD_FILTER, 16'sh7FFF, 6'd0, 32'sh0, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b1, 16'sh7FFF},
        '{ROW_ITEM, CMD_FILTER, 16'sh8000, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b1, 16'sh8000},
        '{ROW_ITEM, CMD_FILTER, 16'sh0000, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b1, 16'sh0000},
        '{ROW_ITEM, CMD_FILTER, 16'shFFFF, 6'd0, 32'sh0, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b1, 16'shFFFF},
        // unity, both extremes, minus one
        '{ROW_ITEM, CMD_LOAD, 16'sh7FFF, 6'd0, 32'sh0001_0000, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_LOAD, 16'sh0, 6'd1, 32'sh7FFF_FFFF, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_LOAD, 16'sh0, 6'd63, 32'sh8000_0000, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_LOAD, 16'sh0, 6'd2, 32'shFFFF_0000, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        // single unity tap; the most negative sample clips to -limit
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'd1,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sd1234, 6'd0, 32'sh0, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b1, 16'sd1234},
        '{ROW_ITEM, CMD_FILTER, 16'sh8000, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b1, -16'sd32767},
        // huge second tap, saturates both ways
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'd2,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sh7FFF, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sh8000, 6'd0, 32'sh0, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_CLIP_MAX, 16'd1,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sd100, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        // zero limit forces silence
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_CLIP_MAX, 16'd0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sd500, 6'd0, 32'sh0, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b1, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sh8000, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b1, 16'sh0},
        // all-ones data: limit masks to 32767, tap count to 127 (beyond TAPS)
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_CLIP_MAX, 16'hFFFF,
          1'b0, 16'sh0},
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'hFFFF,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sd7, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, -16'sd9, 6'd0, 32'sh0, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sh7FFF, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        // spare register indexes must change nothing
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_SPARE_2, 16'h0000,
          1'b0, 16'sh0},
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_SPARE_3, 16'hFFFF,
          1'b0, 16'sh0},
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'd64,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, 16'sd321, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, -16'sd321, 6'd0, 32'sh0, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b0, 16'sh0},
        // back to bypass, history kept
        '{ROW_REG, CMD_FILTER, 16'sh0, 6'd0, 32'sh0, 1'b0, CFG_TAP_COUNT, 16'd0,
          1'b0, 16'sh0},
        '{ROW_ITEM, CMD_FILTER, -16'sd5, 6'd0, 32'sh0, 1'b1, CFG_TAP_COUNT, 16'h0,
          1'b1, -16'sd5}
    };

    fir_filter_clipped_core #(
        .TAPS        (TAPS),
        .FRAC_BITS   (FRAC),
        .SAMPLE_BITS (SW)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_cmd        (in_cmd),
        .i_sample_in  (in_sample),
        .i_coef_index (in_coef_idx),
        .i_coef_value (in_coef),
        .i_last_in    (in_last),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_sample_out (out_sample),
        .o_last_out   (out_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // shift in one sample and return the clamped, scaled sum of products
    function automatic logic signed [SW-1:0] fir_response(input logic signed [SW-1:0] x);
        longint acc;
        longint lim;
        int     n;
        for (int k = TAPS - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = x;
        n = (taps_r > TAPS) ? TAPS : int'(taps_r);
        if (n == 0) return x;
        acc = 0;
        for (int k = 0; k < n; k++) begin
            acc += longint'(coef_tab[k]) * longint'(hist[k]);
            if (acc > SUM_BOUND) acc = SUM_BOUND;
            else if (acc < -SUM_BOUND) acc = -SUM_BOUND;
        end
        lim = longint'(clip_r) <<< FRAC;
        if (acc > lim || acc < -lim) n_clipped++;
        if (acc > lim) acc = lim;
        else if (acc < -lim) acc = -lim;
        return SW'(acc >>> FRAC);
    endfunction

    task automatic flag(input string msg);
        n_bad++;
        if (n_bad <= 10) $display("%s", msg);
    endtask

    // let the core go quiet: all samples out, any trailing load finished
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        n_regs++;
        if (idx == CFG_TAP_COUNT) taps_r = data[TAPCNT_W-1:0];
        else if (idx == CFG_CLIP_MAX) clip_r = data[CLIP_W-1:0];
    endtask

    // valid is left high after the handshake; the next call either lowers
    // it for a gap or replaces the payload
    task automatic push_item(input logic cmd, input logic signed [SW-1:0] smp,
                             input logic [COEF_IDX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] coef, input logic lst,
                             input logic known, input logic signed [SW-1:0] want);
        logic signed [SW-1:0] y;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_cmd      <= cmd;
        in_sample   <= smp;
        in_coef_idx <= idx;
        in_coef     <= coef;
        in_last     <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (cmd == CMD_LOAD) begin
            coef_tab[idx] = coef;
            n_loads++;
        end else begin
            y = fir_response(smp);
            if (known) y = want;
            expected_samples.push_back('{smp: y, lst: lst});
            n_samples++;
        end
    endtask

    // output side
    initial begin
        t_out_sample e;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (expected_samples.size() == 0) begin
                    flag($sformatf("unexpected item: sample %0d last %0b",
                                   out_sample, out_last));
                end else begin
                    e = expected_samples.pop_front();
                    if (out_sample !== e.smp)
                        flag($sformatf("sample_out mismatch: expected %0d, got %0d",
                                       e.smp, out_sample));
                    if (out_last !== e.lst)
                        flag($sformatf("last_out mismatch: expected %0b, got %0b",
                                       e.lst, out_last));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        logic                     r_cmd;
        logic signed [SW-1:0]     r_smp;
        logic signed [COEF_W-1:0] r_coef;
        int                       t_cnt;
        int                       lim;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_tab[r].kind == ROW_REG) begin
                settle();
                write_reg(dir_tab[r].reg_idx, dir_tab[r].reg_data);
            end else begin
                push_item(dir_tab[r].cmd, dir_tab[r].smp, dir_tab[r].idx, dir_tab[r].coef,
                          dir_tab[r].lst, dir_tab[r].known, dir_tab[r].want);
            end
        end

        for (int seg = 0; seg < N_SEG; seg++) begin
            if (seg == 4) begin
                send_idle = 86;
                recv_idle = 25;
            end else if (seg == 8) begin
                send_idle = 0;
                recv_idle = 0;
            end
            settle();
            case (seg)
                0: begin t_cnt = 1;   lim = 32767; end
                1: begin t_cnt = 64;  lim = 32767; end
                2: begin t_cnt = 0;   lim = 1;     end
                3: begin t_cnt = 127; lim = 1;     end
                default: begin
                    t_cnt = $urandom_range(127);
                    lim   = ($urandom_range(9) == 0) ? 0 : $urandom_range(32767);
                end
            endcase
            // junk in the unused upper data bits
            write_reg(CFG_TAP_COUNT, {9'($urandom), 7'(t_cnt)});
            write_reg(CFG_CLIP_MAX, {1'($urandom), 15'(lim)});
            if (seg % 2 == 1)
                write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, 16'($urandom));

            for (int i = 0; i < SEG_ITEMS; i++) begin
                r_cmd = ($urandom_range(9) < 3) ? CMD_LOAD : CMD_FILTER;
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(3))
                        0: r_smp = 16'sh7FFF;
                        1: r_smp = 16'sh8000;
                        2: r_smp = 16'sh0000;
                        default: r_smp = 16'shFFFF;
                    endcase
                end else begin
                    r_smp = SW'($urandom);
                end
                // mostly gains within +/-2.0 so that sums stay below the limit
                case ($urandom_range(9))
                    0: r_coef = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    1, 2: r_coef = $urandom;
                    default: r_coef = 32'($urandom_range(262144)) - 32'sd131072;
                endcase
                push_item(r_cmd, r_smp, COEF_IDX_W'($urandom_range(63)), r_coef,
                          1'($urandom), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (DRAIN + 10) @(posedge clk);

        $display("covered %0d samples (%0d at the clip limit), %0d coefficient loads, %0d register writes",
                 n_samples, n_clipped, n_loads, n_regs);
        $display("mismatches: %0d, samples still owed: %0d", n_bad, expected_samples.size());
        if (n_bad == 0 && expected_samples.size() == 0) begin
            $display("fir_filter_clipped_core_tb passed");
        end else begin
            $display("fir_filter_clipped_core_tb failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout waiting on the core");
        $display("fir_filter_clipped_core_tb failed");
        $finish;
    end

endmodule
